[rtl/osc_pkg.sv]
// Shared types and constants for the occupied slot cursor.
`default_nettype none

package osc_pkg;

    localparam int CELLS_DEFAULT = 16;

    localparam int CMD_W      = 3;
    localparam int SLOT_W     = 4;
    localparam int CURSOR_W   = 5;
    localparam int COUNT_W    = 5;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_FORWARD    = 3'd0,
        CMD_BACK       = 3'd1,
        CMD_GOTO       = 3'd2,
        CMD_MARK_USED  = 3'd3,
        CMD_WIPE       = 3'd4,
        CMD_REVALIDATE = 3'd5
    } cmd_t;

endpackage

`default_nettype wire

[rtl/occupied_slot_cursor_top.sv]
// Top level of the occupied slot cursor: in-use marks, cursor and command stream.
`default_nettype none

// The block keeps one in-use mark per slot and a cursor that is a slot index or
// CELLS for none. Each command item gives exactly one result item. An item is
// captured in an input register; once the output register can advance, priority
// encoders over the in-use mask compute the new cursor, the marks and the result
// item, which goes into the output register. One item can be taken every cycle
// while the downstream side does not stall. The output register holds a result
// while the downstream side stalls. The input register still takes one more
// item during that stall.
module occupied_slot_cursor_top #(
    parameter int CELLS = osc_pkg::CELLS_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // Fields from bit 0: command[2:0], slot[6:3], zero fill[7].
    input  wire logic [osc_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // Fields from bit 0: play[0], play_slot[4:1], cursor[9:5], used_count[14:10],
    // zero fill[15].
    output logic [osc_pkg::OUT_DATA_W-1:0]      m_tdata
);

    import osc_pkg::*;

    localparam int CW = $clog2(CELLS + 1);
    localparam logic [CW-1:0] CUR_NONE = CW'(CELLS);

    logic                  in_valid_reg;
    cmd_t                  in_cmd_reg;
    logic [SLOT_W-1:0]     in_slot_reg;
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;
    logic [CELLS-1:0]      mask_reg;
    logic [CELLS-1:0]      mask_next;
    logic [CW-1:0]         cur_reg;
    logic [CW-1:0]         cur_next;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;

    logic                  advance;
    logic                  work;

    logic [CW-1:0]         low_all;
    logic [CW-1:0]         high_all;
    logic [CW-1:0]         above_cur;
    logic [CW-1:0]         below_cur;
    logic                  above_found;
    logic                  below_found;
    logic                  cur_used;
    logic                  slot_used;
    logic                  slot_in_range;
    logic [CW-1:0]         revalid;
    logic                  play;
    logic [7:0]            cur_wide;
    logic [7:0]            count_wide;
    logic [SLOT_W-1:0]     play_slot;

    assign advance  = !out_valid_reg || m_tready;
    assign work     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        low_all     = CUR_NONE;
        high_all    = CUR_NONE;
        above_cur   = CUR_NONE;
        below_cur   = CUR_NONE;
        above_found = 1'b0;
        below_found = 1'b0;
        cur_used    = 1'b0;
        slot_used   = 1'b0;
        for (int i = CELLS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                low_all = CW'(i);
                if (CW'(i) > cur_reg)
                begin
                    above_cur   = CW'(i);
                    above_found = 1'b1;
                end
            end
        end
        for (int i = 0; i < CELLS; i++)
        begin
            if (mask_reg[i])
            begin
                high_all = CW'(i);
                if (CW'(i) < cur_reg)
                begin
                    below_cur   = CW'(i);
                    below_found = 1'b1;
                end
                if (CW'(i) == cur_reg)
                begin
                    cur_used = 1'b1;
                end
                if (int'(in_slot_reg) == i)
                begin
                    slot_used = 1'b1;
                end
            end
        end
    end

    assign slot_in_range = int'(in_slot_reg) < CELLS;

    always_comb
    begin
        if (count_reg == '0)
        begin
            revalid = CUR_NONE;
        end
        else if (cur_used)
        begin
            revalid = cur_reg;
        end
        else if (cur_reg >= CUR_NONE)
        begin
            revalid = low_all;
        end
        else if (below_found)
        begin
            revalid = below_cur;
        end
        else
        begin
            revalid = above_cur;
        end
    end

    always_comb
    begin
        mask_next  = mask_reg;
        cur_next   = cur_reg;
        count_next = count_reg;
        play       = 1'b0;
        case (in_cmd_reg)
            CMD_FORWARD, CMD_BACK:
            begin
                if (!cur_used)
                begin
                    cur_next = revalid;
                    play     = count_reg != '0;
                end
                else if (count_reg > CW'(1))
                begin
                    play = 1'b1;
                    if (in_cmd_reg == CMD_FORWARD)
                    begin
                        cur_next = above_found ? above_cur : low_all;
                    end
                    else
                    begin
                        cur_next = below_found ? below_cur : high_all;
                    end
                end
            end
            CMD_GOTO:
            begin
                if (slot_used)
                begin
                    cur_next = CW'(in_slot_reg);
                    play     = 1'b1;
                end
            end
            CMD_MARK_USED:
            begin
                if (slot_in_range && !slot_used)
                begin
                    for (int i = 0; i < CELLS; i++)
                    begin
                        if (int'(in_slot_reg) == i)
                        begin
                            mask_next[i] = 1'b1;
                        end
                    end
                    count_next = count_reg + CW'(1);
                end
            end
            CMD_WIPE:
            begin
                mask_next  = '0;
                cur_next   = CUR_NONE;
                count_next = '0;
            end
            CMD_REVALIDATE:
            begin
                cur_next = revalid;
            end
            default:
            begin
                play = 1'b0;
            end
        endcase
    end

    assign cur_wide      = 8'(cur_next);
    assign count_wide    = 8'(count_next);
    assign play_slot     = play ? cur_wide[SLOT_W-1:0] : '0;
    assign out_data_next = {1'b0, count_wide[COUNT_W-1:0], cur_wide[CURSOR_W-1:0],
                            play_slot, play};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mask_reg      <= '0;
            cur_reg       <= CUR_NONE;
            count_reg     <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (work)
            begin
                mask_reg  <= mask_next;
                cur_reg   <= cur_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_cmd_reg  <= cmd_t'(s_tdata[CMD_W-1:0]);
            in_slot_reg <= s_tdata[CMD_W+SLOT_W-1:CMD_W];
        end
        if (work)
        begin
            out_data_reg <= out_data_next;
        end
    end

    a_cursor_on_used: assert property (@(posedge clk) disable iff (!rst_n)
        cur_reg == CUR_NONE || cur_used)
        else $error("Cursor points at an unused slot.");

    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) == $countones(mask_reg))
        else $error("Used count disagrees with the in-use marks.");

    a_empty_no_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> cur_reg == CUR_NONE)
        else $error("Cursor selects a slot while no slot is used.");

endmodule

`default_nettype wire

[sim/tb_occupied_slot_cursor_top.sv]
// Self-checking testbench for the occupied slot cursor top level.
module tb_occupied_slot_cursor_top;
    import osc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [4:0] NO_SLOT = 5'd16;
    localparam logic [2:0] CMD_UNDEF_A = 3'd6;
    localparam logic [2:0] CMD_UNDEF_B = 3'd7;
    localparam int RANDOM_ITEMS = 1800;
    localparam int DIRECTED_ROWS = 23;

    typedef struct packed {
        logic       play;
        logic [3:0] play_slot;
        logic [4:0] cursor;
        logic [4:0] used_count;
    } slot_result_t;

    typedef struct {
        logic [2:0]   cmd;
        logic [3:0]   slot;
        bit           fixed;
        slot_result_t outcome;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;

    logic [15:0]  track_mask;
    logic [4:0]   track_cursor;
    slot_result_t pending_results[$];
    int           error_count;
    bit           quiet;

    // Rows with fixed set carry their result as written; the others use the tracker.
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{CMD_FORWARD,    4'd0,  1'b1, '{1'b0, 4'd0, NO_SLOT, 5'd0}},
        '{CMD_BACK,       4'd15, 1'b1, '{1'b0, 4'd0, NO_SLOT, 5'd0}},
        '{CMD_GOTO,       4'd0,  1'b1, '{1'b0, 4'd0, NO_SLOT, 5'd0}},
        '{CMD_REVALIDATE, 4'd0,  1'b1, '{1'b0, 4'd0, NO_SLOT, 5'd0}},
        '{CMD_UNDEF_A,    4'd15, 1'b1, '{1'b0, 4'd0, NO_SLOT, 5'd0}},
        '{CMD_UNDEF_B,    4'd0,  1'b1, '{1'b0, 4'd0, NO_SLOT, 5'd0}},
        '{CMD_MARK_USED,  4'd15, 1'b1, '{1'b0, 4'd0, NO_SLOT, 5'd1}},
        '{CMD_FORWARD,    4'd0,  1'b0, '0},
        '{CMD_FORWARD,    4'd0,  1'b0, '0},
        '{CMD_BACK,       4'd0,  1'b0, '0},
        '{CMD_MARK_USED,  4'd0,  1'b0, '0},
        '{CMD_FORWARD,    4'd0,  1'b0, '0},
        '{CMD_BACK,       4'd0,  1'b0, '0},
        '{CMD_GOTO,       4'd7,  1'b0, '0},
        '{CMD_GOTO,       4'd0,  1'b0, '0},
        '{CMD_MARK_USED,  4'd8,  1'b0, '0},
        '{CMD_REVALIDATE, 4'd0,  1'b0, '0},
        '{CMD_UNDEF_B,    4'd8,  1'b0, '0},
        '{CMD_WIPE,       4'd3,  1'b1, '{1'b0, 4'd0, NO_SLOT, 5'd0}},
        '{CMD_REVALIDATE, 4'd0,  1'b1, '{1'b0, 4'd0, NO_SLOT, 5'd0}},
        '{CMD_MARK_USED,  4'd7,  1'b1, '{1'b0, 4'd0, NO_SLOT, 5'd1}},
        '{CMD_BACK,       4'd0,  1'b0, '0},
        '{CMD_WIPE,       4'd0,  1'b1, '{1'b0, 4'd0, NO_SLOT, 5'd0}}
    };

    occupied_slot_cursor_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    function automatic logic [4:0] lowest_used_from(logic [15:0] mask, int start);
        for (int i = start; i < 16; i++)
        begin
            if (mask[i])
                return 5'(i);
        end
        return NO_SLOT;
    endfunction

    function automatic logic [4:0] highest_used_below(logic [15:0] mask, int limit);
        for (int i = limit - 1; i >= 0; i--)
        begin
            if (mask[i])
                return 5'(i);
        end
        return NO_SLOT;
    endfunction

    function automatic logic [4:0] repaired_cursor(logic [15:0] mask, logic [4:0] cur);
        logic [4:0] below;
        if (mask == '0)
            return NO_SLOT;
        if (cur >= NO_SLOT)
            return lowest_used_from(mask, 0);
        if (mask[cur[3:0]])
            return cur;
        below = highest_used_below(mask, int'(cur));
        if (below != NO_SLOT)
            return below;
        return lowest_used_from(mask, int'(cur) + 1);
    endfunction

    function automatic slot_result_t step_tracker(logic [2:0] cmd, logic [3:0] slot);
        slot_result_t res;
        logic         play;
        logic [4:0]   next;
        play = 1'b0;
        case (cmd)
            CMD_FORWARD, CMD_BACK:
            begin
                if (track_cursor >= NO_SLOT || !track_mask[track_cursor[3:0]])
                begin
                    track_cursor = repaired_cursor(track_mask, track_cursor);
                    play = (track_mask != '0);
                end
                else if ($countones(track_mask) > 1)
                begin
                    if (cmd == CMD_FORWARD)
                    begin
                        next = lowest_used_from(track_mask, int'(track_cursor) + 1);
                        if (next == NO_SLOT)
                            next = lowest_used_from(track_mask, 0);
                    end
                    else
                    begin
                        next = highest_used_below(track_mask, int'(track_cursor));
                        if (next == NO_SLOT)
                            next = highest_used_below(track_mask, 16);
                    end
                    track_cursor = next;
                    play = 1'b1;
                end
            end
            CMD_GOTO:
            begin
                if (track_mask[slot])
                begin
                    track_cursor = {1'b0, slot};
                    play = 1'b1;
                end
            end
            CMD_MARK_USED:
                track_mask[slot] = 1'b1;
            CMD_WIPE:
            begin
                track_mask = '0;
                track_cursor = NO_SLOT;
            end
            CMD_REVALIDATE:
                track_cursor = repaired_cursor(track_mask, track_cursor);
            default:
                ;
        endcase
        res.play = play;
        res.play_slot = play ? track_cursor[3:0] : 4'd0;
        res.cursor = track_cursor;
        res.used_count = 5'($countones(track_mask));
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet)
            return 0;
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at %0t: %s is %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic issue_command(input logic [2:0] cmd, input logic [3:0] slot,
                                 input bit fixed, input slot_result_t typed);
        int           gap;
        slot_result_t predicted;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, slot, cmd};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = step_tracker(cmd, slot);
        pending_results.push_back(fixed ? typed : predicted);
    endtask

    always @(posedge clk)
    begin
        slot_result_t got;
        slot_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.play       = m_tdata[0];
            got.play_slot  = m_tdata[4:1];
            got.cursor     = m_tdata[9:5];
            got.used_count = m_tdata[14:10];
            if (pending_results.size() == 0)
                report_mismatch("unexpected item", int'(m_tdata), 0);
            else
            begin
                want = pending_results.pop_front();
                if (got.play !== want.play)
                    report_mismatch("play", int'(got.play), int'(want.play));
                if (got.play_slot !== want.play_slot)
                    report_mismatch("play_slot", int'(got.play_slot),
                                    int'(want.play_slot));
                if (got.cursor !== want.cursor)
                    report_mismatch("cursor", int'(got.cursor), int'(want.cursor));
                if (got.used_count !== want.used_count)
                    report_mismatch("used_count", int'(got.used_count),
                                    int'(want.used_count));
            end
        end
    end

    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left == 0)
                stall_left = pick_gap();
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        logic [2:0] cmd;
        logic [3:0] slot;
        int         r;
        int         mark_weight;
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        quiet = 1'b0;
        error_count = 0;
        track_mask = '0;
        track_cursor = NO_SLOT;
        mark_weight = 20;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            issue_command(directed_rows[i].cmd, directed_rows[i].slot,
                          directed_rows[i].fixed, directed_rows[i].outcome);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 2)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                while (pending_results.size() != 0)
                    @(posedge clk);
            end
            quiet = (n >= 1200 && n < 1400);
            slot = 4'($urandom_range(0, 15));
            r = $urandom_range(0, 99);
            if (r < 1)
            begin
                cmd = CMD_WIPE;
                mark_weight = $urandom_range(5, 45);
            end
            else if (r < 4)
                cmd = $urandom_range(0, 1) ? CMD_UNDEF_A : CMD_UNDEF_B;
            else if (r < 9)
                cmd = CMD_REVALIDATE;
            else if (r < 9 + mark_weight)
                cmd = CMD_MARK_USED;
            else if (r < 24 + mark_weight)
            begin
                cmd = CMD_GOTO;
                if (track_mask != '0 && $urandom_range(0, 3) != 0)
                begin
                    while (!track_mask[slot])
                        slot = 4'($urandom_range(0, 15));
                end
            end
            else
                cmd = $urandom_range(0, 1) ? CMD_FORWARD : CMD_BACK;
            issue_command(cmd, slot, 1'b0, '0);
        end
        quiet = 1'b0;

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[occupied_slot_cursor_top.f]
rtl/osc_pkg.sv
rtl/occupied_slot_cursor_top.sv
sim/tb_occupied_slot_cursor_top.sv
